// ===== rtl/tcw_pkg.sv =====
// shared constants, types and handshake structs of the text console writer
package tcw_pkg;

    localparam int COLS_DEF     = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STOP_DEF = 4;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_FIRST = 8'h21;
    localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7E;

    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] read_char;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic              scrolled;
        logic              cleared;
        logic              drew;
        logic [COL_W-1:0]  draw_col;
        logic [ROW_W-1:0]  draw_row;
        logic [CHAR_W-1:0] draw_char;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic issue_read;
        logic fill_step;
        logic commit_put;
        logic commit_read;
    } cmd_t;

    typedef struct packed {
        logic is_read;
        logic need_fill;
        logic fill_last;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/tcw_if.sv =====
// request and response channel interfaces of the text console writer
interface tcw_req_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [tcw_pkg::CHAR_W-1:0] char_code;
    logic [tcw_pkg::ROW_W-1:0]  read_row;
    logic [tcw_pkg::COL_W-1:0]  read_col;

    modport source (output valid, output req_type, output char_code, output read_row,
                    output read_col, input ready);
    modport sink (input valid, input req_type, input char_code, input read_row,
                  input read_col, output ready);
endinterface

interface tcw_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [tcw_pkg::CHAR_W-1:0] read_char;
    logic [tcw_pkg::COL_W-1:0]  cursor_col;
    logic [tcw_pkg::ROW_W-1:0]  cursor_row;
    logic                      scrolled;
    logic                      cleared;
    logic                      drew;
    logic [tcw_pkg::COL_W-1:0]  draw_col;
    logic [tcw_pkg::ROW_W-1:0]  draw_row;
    logic [tcw_pkg::CHAR_W-1:0] draw_char;

    modport source (output valid, output read_char, output cursor_col, output cursor_row,
                    output scrolled, output cleared, output drew, output draw_col,
                    output draw_row, output draw_char, input ready);
    modport sink (input valid, input read_char, input cursor_col, input cursor_row,
                  input scrolled, input cleared, input drew, input draw_col,
                  input draw_row, input draw_char, output ready);
endinterface

// ===== rtl/tcw_ram.sv =====
// generic single write port ram with registered read
module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tcw_ctrl.sv =====
// sequencing state machine of the text console writer
module tcw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tcw_pkg::status_t  status,
    output tcw_pkg::cmd_t     cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WORK  = 2'd1;
    localparam logic [1:0] S_FILL  = 2'd2;
    localparam logic [1:0] S_RDONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_WORK;
                end
            end
            S_WORK:
            begin
                if (status.is_read)
                begin
                    cmd.issue_read = 1'b1;
                    state_next     = S_RDONE;
                end
                else if (status.need_fill)
                begin
                    state_next = S_FILL;
                end
                else if (status.out_free)
                begin
                    cmd.commit_put = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (status.fill_last)
                begin
                    state_next = S_WORK;
                end
            end
            S_RDONE:
            begin
                if (status.out_free)
                begin
                    cmd.commit_read = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// ===== rtl/tcw_datapath.sv =====
// cursor, row ring, screen store and response register of the text console writer
module tcw_datapath #(
    parameter int COLS     = tcw_pkg::COLS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tcw_pkg::cmd_t     cmd,
    output tcw_pkg::status_t  status,
    input  tcw_pkg::req_t     req_data,
    output tcw_pkg::rsp_t     rsp_data,
    output logic              rsp_valid,
    input  logic              rsp_ready
);

    localparam int COL_W  = tcw_pkg::COL_W;
    localparam int ROW_W  = tcw_pkg::ROW_W;
    localparam int CHAR_W = tcw_pkg::CHAR_W;
    localparam int CW1    = COL_W + 1;
    localparam int PR_W   = $clog2(ROWS);
    localparam int PH_W   = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int DEPTH  = ROWS * COLS;
    localparam int ADDR_W = $clog2(DEPTH);

    tcw_pkg::req_t     item_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [PH_W-1:0]   phase_reg;
    logic [PR_W-1:0]   top_reg;
    logic [ROWS-1:0]   valid_reg;
    logic [COL_W-1:0]  fill_reg;
    logic              rd_oor_reg;
    logic              rd_blank_reg;
    tcw_pkg::rsp_t     out_reg;
    logic              out_valid_reg;

    logic [PR_W:0]     sum_c;
    logic [PR_W-1:0]   phys_c;
    logic [PR_W:0]     sum_r;
    logic [PR_W-1:0]   phys_r;
    logic              rd_in_range;

    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_next;
    logic [PH_W-1:0]   phase_next;
    logic              scr;
    logic              clr;
    logic              drew;
    logic              nl;
    logic              advance;
    logic              printable;
    logic [CHAR_W-1:0] wchar;
    logic [CW1-1:0]    col_p1;
    logic [CW1-1:0]    col_tab;
    logic [PH_W-1:0]   ph_inc;
    logic [PH_W-1:0]   ph_dec;

    logic              ram_wr_en;
    logic [COL_W-1:0]  wcol;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [CHAR_W-1:0] ram_wr_data;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [CHAR_W-1:0] ram_rd_data;
    logic              fill_last;

    // physical rows in the ring
    assign sum_c  = {1'b0, top_reg} + (PR_W+1)'(row_reg);
    assign phys_c = (sum_c >= (PR_W+1)'(ROWS)) ? PR_W'(sum_c - (PR_W+1)'(ROWS))
                                               : sum_c[PR_W-1:0];
    assign sum_r  = {1'b0, top_reg} + (PR_W+1)'(item_reg.read_row);
    assign phys_r = (sum_r >= (PR_W+1)'(ROWS)) ? PR_W'(sum_r - (PR_W+1)'(ROWS))
                                               : sum_r[PR_W-1:0];
    assign rd_in_range = (32'(item_reg.read_row) < 32'(ROWS))
                      && (32'(item_reg.read_col) < 32'(COLS));

    assign printable = (item_reg.char_code >= tcw_pkg::CH_FIRST)
                    && (item_reg.char_code <= tcw_pkg::CH_LAST);
    assign col_p1  = {1'b0, col_reg} + CW1'(1);
    assign col_tab = {1'b0, col_reg} + CW1'(TAB_STOP) - CW1'(phase_reg);
    assign ph_inc  = (phase_reg == PH_W'(TAB_STOP - 1)) ? '0 : phase_reg + PH_W'(1);
    assign ph_dec  = (phase_reg == '0) ? PH_W'(TAB_STOP - 1) : phase_reg - PH_W'(1);

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        phase_next = phase_reg;
        scr        = 1'b0;
        clr        = 1'b0;
        drew       = 1'b0;
        nl         = 1'b0;
        advance    = 1'b0;
        wchar      = tcw_pkg::CH_SPACE;
        case (item_reg.char_code)
            tcw_pkg::CH_TAB:
            begin
                if (col_tab >= CW1'(COLS))
                begin
                    nl = 1'b1;
                end
                else
                begin
                    col_next   = col_tab[COL_W-1:0];
                    phase_next = '0;
                end
            end
            tcw_pkg::CH_NL:
            begin
                nl = 1'b1;
            end
            tcw_pkg::CH_BS:
            begin
                if (col_reg != '0)
                begin
                    drew       = 1'b1;
                    col_next   = col_reg - COL_W'(1);
                    phase_next = ph_dec;
                end
            end
            tcw_pkg::CH_CR:
            begin
                col_next   = '0;
                phase_next = '0;
            end
            tcw_pkg::CH_FF:
            begin
                clr        = 1'b1;
                col_next   = '0;
                row_next   = '0;
                phase_next = '0;
            end
            tcw_pkg::CH_SPACE:
            begin
                advance = 1'b1;
            end
            default:
            begin
                if (printable)
                begin
                    drew    = 1'b1;
                    wchar   = item_reg.char_code;
                    advance = 1'b1;
                end
            end
        endcase
        if (advance)
        begin
            if (col_p1 >= CW1'(COLS))
            begin
                nl = 1'b1;
            end
            else
            begin
                col_next   = col_p1[COL_W-1:0];
                phase_next = ph_inc;
            end
        end
        if (nl)
        begin
            col_next   = '0;
            phase_next = '0;
            if (row_reg == ROW_W'(ROWS - 1))
            begin
                scr = 1'b1;
            end
            else
            begin
                row_next = row_reg + ROW_W'(1);
            end
        end
    end

    // screen store, a never written or blanked row is tracked by its valid bit
    assign fill_last   = (fill_reg == COL_W'(COLS - 1));
    assign wcol        = cmd.fill_step ? fill_reg : col_reg;
    assign ram_wr_en   = cmd.fill_step || (cmd.commit_put && drew);
    assign ram_wr_addr = ADDR_W'(phys_c) * ADDR_W'(COLS) + ADDR_W'(wcol);
    assign ram_wr_data = cmd.fill_step ? tcw_pkg::CH_SPACE : wchar;
    assign ram_rd_addr = ADDR_W'(phys_r) * ADDR_W'(COLS) + ADDR_W'(item_reg.read_col);

    tcw_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_screen (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.issue_read),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            phase_reg     <= '0;
            top_reg       <= '0;
            valid_reg     <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.fill_step)
            begin
                fill_reg <= fill_last ? '0 : fill_reg + COL_W'(1);
                if (fill_last)
                begin
                    valid_reg[phys_c] <= 1'b1;
                end
            end
            if (cmd.commit_put)
            begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                phase_reg <= phase_next;
                if (clr)
                begin
                    valid_reg <= '0;
                    top_reg   <= '0;
                end
                else if (scr)
                begin
                    valid_reg[top_reg] <= 1'b0;
                    top_reg <= (top_reg == PR_W'(ROWS - 1)) ? '0 : top_reg + PR_W'(1);
                end
            end
            if (cmd.commit_put || cmd.commit_read)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req_data;
        end
        if (cmd.issue_read)
        begin
            rd_oor_reg   <= !rd_in_range;
            rd_blank_reg <= rd_in_range ? !valid_reg[phys_r] : 1'b1;
        end
        if (cmd.commit_put)
        begin
            out_reg.read_char  <= '0;
            out_reg.cursor_col <= col_next;
            out_reg.cursor_row <= row_next;
            out_reg.scrolled   <= scr;
            out_reg.cleared    <= clr;
            out_reg.drew       <= drew;
            out_reg.draw_col   <= drew ? col_reg : '0;
            out_reg.draw_row   <= drew ? row_reg : '0;
            out_reg.draw_char  <= drew ? wchar : '0;
        end
        else if (cmd.commit_read)
        begin
            out_reg.read_char  <= rd_oor_reg   ? '0 :
                                  rd_blank_reg ? tcw_pkg::CH_SPACE : ram_rd_data;
            out_reg.cursor_col <= col_reg;
            out_reg.cursor_row <= row_reg;
            out_reg.scrolled   <= 1'b0;
            out_reg.cleared    <= 1'b0;
            out_reg.drew       <= 1'b0;
            out_reg.draw_col   <= '0;
            out_reg.draw_row   <= '0;
            out_reg.draw_char  <= '0;
        end
    end

    assign status.is_read   = (item_reg.req_type == tcw_pkg::REQ_READ);
    assign status.need_fill = (item_reg.req_type == tcw_pkg::REQ_PUT) && printable
                           && !valid_reg[phys_c];
    assign status.fill_last = fill_last;
    assign status.out_free  = !out_valid_reg || rsp_ready;

    assign rsp_data  = out_reg;
    assign rsp_valid = out_valid_reg;

endmodule

// ===== rtl/text_console_char_writer_core.sv =====
// top level of the text console writer: controller, datapath and channel wiring
//
//  channel | dir | handshake       | payload
//  req     | in  | valid / ready   | req_type, char_code, read_row, read_col
//  rsp     | out | valid / ready   | read_char, cursor, scroll/clear flags, draw cell
//
// a put registers its result in the work state once the output register is free
// a read reads the ram in the work state and registers its result in the read-done state
// a printable byte landing on a row not written since reset, scroll or form feed
// first sweeps that row with spaces, column by column, through the single write port
// reset marks every row blank through per-row valid bits, so no clearing pass is run
// one transaction is in flight at a time; a new one is taken while the last
// result waits in the output register, and a stalled output holds the next commit
module text_console_char_writer_core #(
    parameter int COLS     = tcw_pkg::COLS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
    input logic      clk,
    input logic      rst_n,
    tcw_req_if.sink  req,
    tcw_rsp_if.source rsp
);

    tcw_pkg::cmd_t    cmd;
    tcw_pkg::status_t status;
    tcw_pkg::req_t    req_data;
    tcw_pkg::rsp_t    rsp_data;
    logic             in_ready;

    assign req_data.req_type  = req.req_type;
    assign req_data.char_code = req.char_code;
    assign req_data.read_row  = req.read_row;
    assign req_data.read_col  = req.read_col;
    assign req.ready          = in_ready;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tcw_datapath #(
        .COLS     (COLS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req_data  (req_data),
        .rsp_data  (rsp_data),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready)
    );

    assign rsp.read_char  = rsp_data.read_char;
    assign rsp.cursor_col = rsp_data.cursor_col;
    assign rsp.cursor_row = rsp_data.cursor_row;
    assign rsp.scrolled   = rsp_data.scrolled;
    assign rsp.cleared    = rsp_data.cleared;
    assign rsp.drew       = rsp_data.drew;
    assign rsp.draw_col   = rsp_data.draw_col;
    assign rsp.draw_row   = rsp_data.draw_row;
    assign rsp.draw_char  = rsp_data.draw_char;

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench of the text console character writer core
`timescale 1ns / 1ps

module testbench;

    localparam int N_COLS   = tcw_pkg::COLS_DEF;
    localparam int N_ROWS   = tcw_pkg::ROWS_DEF;
    localparam int TAB_W    = tcw_pkg::TAB_STOP_DEF;
    localparam int COLW     = tcw_pkg::COL_W;
    localparam int ROWW     = tcw_pkg::ROW_W;
    localparam int CHW      = tcw_pkg::CHAR_W;
    localparam int RANDOM_ITEMS = 780;
    localparam int MAX_REPORTS  = 40;

    logic clk;
    logic rst_n;

    tcw_req_if req_ch ();
    tcw_rsp_if rsp_ch ();

    text_console_char_writer_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    tcw_pkg::req_t pending_reqs[$];
    tcw_pkg::rsp_t awaited_rsps[$];
    tcw_pkg::req_t offered_req;

    logic [CHW-1:0]  screen_copy [N_ROWS][N_COLS];
    logic [COLW-1:0] con_col;
    logic [ROWW-1:0] con_row;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_cycles    = 0;
    int unsigned pushed_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned workload_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned result_count   = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("text_console_char_writer_core: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_REPORTS)
            $display("result %0d %s: got %0h, expected %0h", result_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task automatic apply_to_screen(input tcw_pkg::req_t r, output tcw_pkg::rsp_t o);
        int   col;
        int   row;
        logic wrap;
        o    = '0;
        col  = int'(con_col);
        row  = int'(con_row);
        wrap = 1'b0;
        if (r.req_type == tcw_pkg::REQ_READ)
        begin
            if (r.read_row < N_ROWS && r.read_col < N_COLS)
                o.read_char = screen_copy[r.read_row][r.read_col];
        end
        else
        begin
            case (r.char_code)
                tcw_pkg::CH_TAB:
                begin
                    col  = (col / TAB_W + 1) * TAB_W;
                    wrap = (col >= N_COLS);
                end
                tcw_pkg::CH_NL:
                    wrap = 1'b1;
                tcw_pkg::CH_BS:
                begin
                    if (col > 0)
                    begin
                        screen_copy[row][col] = tcw_pkg::CH_SPACE;
                        o.drew      = 1'b1;
                        o.draw_col  = COLW'(col);
                        o.draw_row  = ROWW'(row);
                        o.draw_char = tcw_pkg::CH_SPACE;
                        col--;
                    end
                end
                tcw_pkg::CH_CR:
                    col = 0;
                tcw_pkg::CH_FF:
                begin
                    foreach (screen_copy[i, j])
                        screen_copy[i][j] = tcw_pkg::CH_SPACE;
                    col       = 0;
                    row       = 0;
                    o.cleared = 1'b1;
                end
                tcw_pkg::CH_SPACE:
                begin
                    col++;
                    wrap = (col >= N_COLS);
                end
                default:
                begin
                    if (r.char_code >= tcw_pkg::CH_FIRST && r.char_code <= tcw_pkg::CH_LAST)
                    begin
                        screen_copy[row][col] = r.char_code;
                        o.drew      = 1'b1;
                        o.draw_col  = COLW'(col);
                        o.draw_row  = ROWW'(row);
                        o.draw_char = r.char_code;
                        col++;
                        wrap = (col >= N_COLS);
                    end
                end
            endcase
            if (wrap)
            begin
                col = 0;
                if (row == N_ROWS - 1)
                begin
                    for (int i = 0; i < N_ROWS - 1; i++)
                        screen_copy[i] = screen_copy[i + 1];
                    for (int j = 0; j < N_COLS; j++)
                        screen_copy[N_ROWS - 1][j] = tcw_pkg::CH_SPACE;
                    o.scrolled = 1'b1;
                end
                else
                begin
                    row++;
                end
            end
        end
        con_col      = COLW'(col);
        con_row      = ROWW'(row);
        o.cursor_col = con_col;
        o.cursor_row = con_row;
    endtask

    function automatic tcw_pkg::req_t put_req(input logic [CHW-1:0] code);
        tcw_pkg::req_t r;
        r.req_type  = tcw_pkg::REQ_PUT;
        r.char_code = code;
        r.read_row  = ROWW'($urandom_range(0, 31));
        r.read_col  = COLW'($urandom_range(0, 127));
        return r;
    endfunction

    function automatic tcw_pkg::req_t read_req(input int row, input int col);
        tcw_pkg::req_t r;
        r.req_type  = tcw_pkg::REQ_READ;
        r.char_code = CHW'($urandom_range(0, 255));
        r.read_row  = ROWW'(row);
        r.read_col  = COLW'(col);
        return r;
    endfunction

    task automatic push_req(input tcw_pkg::req_t r);
        pending_reqs.push_back(r);
        pushed_count++;
        if (r.req_type == tcw_pkg::REQ_READ
                || r.char_code inside {tcw_pkg::CH_TAB, tcw_pkg::CH_NL, tcw_pkg::CH_BS,
                                       tcw_pkg::CH_CR, tcw_pkg::CH_FF, tcw_pkg::CH_SPACE}
                || (r.char_code >= tcw_pkg::CH_FIRST && r.char_code <= tcw_pkg::CH_LAST))
            workload_count++;
    endtask

    task automatic push_random_read();
        if ($urandom_range(0, 99) < 85)
            push_req(read_req($urandom_range(0, 1) ? $urandom_range(0, N_ROWS - 1)
                                                   : $urandom_range(N_ROWS - 5, N_ROWS - 1),
                              $urandom_range(0, N_COLS - 1)));
        else
            push_req(read_req($urandom_range(0, 31), $urandom_range(0, 127)));
    endtask

    task automatic queue_random_burst();
        int kind;
        int n;
        int pick;
        kind = $urandom_range(0, 99);
        if (kind < 60)
        begin
            n = $urandom_range(1, 90);
            for (int i = 0; i < n; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    push_req(put_req(CHW'($urandom_range(tcw_pkg::CH_FIRST,
                                                         tcw_pkg::CH_LAST))));
                else if (pick < 87)
                    push_req(put_req(tcw_pkg::CH_SPACE));
                else if (pick < 93)
                    push_req(put_req(tcw_pkg::CH_TAB));
                else if (pick < 96)
                    push_req(put_req(tcw_pkg::CH_BS));
                else
                    push_random_read();
            end
            pick = $urandom_range(0, 9);
            if (pick < 7)
                push_req(put_req(tcw_pkg::CH_NL));
            else if (pick == 7)
                push_req(put_req(tcw_pkg::CH_CR));
        end
        else if (kind < 80)
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                push_random_read();
        end
        else if (kind < 90)
        begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
                push_req(put_req(tcw_pkg::CH_NL));
        end
        else if (kind < 98)
        begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    push_random_read();
                else
                    push_req(put_req(CHW'($urandom_range(0, 255))));
            end
        end
        else
        begin
            push_req(put_req(tcw_pkg::CH_FF));
        end
    endtask

    task automatic wait_drained();
        while (accepted_count != pushed_count || awaited_rsps.size() != 0)
            @(posedge clk);
    endtask

    // request driver
    always @(posedge clk)
    begin
        tcw_pkg::rsp_t want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                apply_to_screen(offered_req, want);
                awaited_rsps.push_back(want);
                accepted_count++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    offered_req = pending_reqs.pop_front();
                    req_ch.valid     <= 1'b1;
                    req_ch.req_type  <= offered_req.req_type;
                    req_ch.char_code <= offered_req.char_code;
                    req_ch.read_row  <= offered_req.read_row;
                    req_ch.read_col  <= offered_req.read_col;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_cycles != 0)
            hold_cycles <= hold_cycles - 1;
    end

    // response monitor
    always @(posedge clk)
    begin
        tcw_pkg::rsp_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                result_count++;
                if (awaited_rsps.size() == 0)
                begin
                    report_mismatch("unexpected transaction", int'(rsp_ch.cursor_col), 0);
                end
                else
                begin
                    want = awaited_rsps.pop_front();
                    check_field("read_char", int'(rsp_ch.read_char), int'(want.read_char));
                    check_field("cursor_col", int'(rsp_ch.cursor_col),
                                int'(want.cursor_col));
                    check_field("cursor_row", int'(rsp_ch.cursor_row),
                                int'(want.cursor_row));
                    check_field("scrolled", int'(rsp_ch.scrolled), int'(want.scrolled));
                    check_field("cleared", int'(rsp_ch.cleared), int'(want.cleared));
                    check_field("drew", int'(rsp_ch.drew), int'(want.drew));
                    check_field("draw_col", int'(rsp_ch.draw_col), int'(want.draw_col));
                    check_field("draw_row", int'(rsp_ch.draw_row), int'(want.draw_row));
                    check_field("draw_char", int'(rsp_ch.draw_char), int'(want.draw_char));
                end
            end
            if (hold_cycles != 0)
                rsp_ch.ready <= 1'b0;
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        req_ch.valid     = 1'b0;
        req_ch.req_type  = tcw_pkg::REQ_PUT;
        req_ch.char_code = '0;
        req_ch.read_row  = '0;
        req_ch.read_col  = '0;
        rsp_ch.ready     = 1'b0;
        con_col          = '0;
        con_row          = '0;
        foreach (screen_copy[i, j])
            screen_copy[i][j] = tcw_pkg::CH_SPACE;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // field extremes and every control byte
        push_req(read_req(0, 0));
        push_req(read_req(N_ROWS - 1, N_COLS - 1));
        push_req(read_req(31, 127));
        push_req(read_req(N_ROWS, 0));
        push_req(read_req(0, N_COLS));
        push_req(put_req(tcw_pkg::CH_FIRST));
        push_req(put_req(tcw_pkg::CH_LAST));
        push_req(read_req(0, 0));
        push_req(put_req(8'h00));
        push_req(put_req(8'h1F));
        push_req(put_req(8'h7F));
        push_req(put_req(8'hFF));
        push_req(put_req(tcw_pkg::CH_SPACE));
        push_req(put_req(tcw_pkg::CH_TAB));
        push_req(put_req(tcw_pkg::CH_BS));
        push_req(put_req(tcw_pkg::CH_CR));
        push_req(put_req(tcw_pkg::CH_BS));
        push_req(put_req(tcw_pkg::CH_NL));
        push_req(put_req(tcw_pkg::CH_TAB));
        push_req(read_req(0, 1));
        push_req(put_req(tcw_pkg::CH_FF));
        push_req(read_req(0, 0));
        wait_drained();

        workload_count = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 81;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 81;
                end
                default:
                begin
                    send_idle_pct  = 20;
                    recv_stall_pct = 20;
                end
            endcase
            while (workload_count < RANDOM_ITEMS * (phase + 1) / 4)
                queue_random_burst();
            wait_drained();
        end

        // receiver blocked while the sender keeps offering
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge clk);
        hold_cycles <= 400;
        for (int i = 0; i < 40; i++)
            push_req(put_req(CHW'($urandom_range(tcw_pkg::CH_FIRST, tcw_pkg::CH_LAST))));
        wait_drained();

        repeat (2 * N_COLS + 20) @(posedge clk);
        if (mismatch_count == 0)
            $display("text_console_char_writer_core: match");
        else
            $display("text_console_char_writer_core: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tcw_pkg.sv
rtl/tcw_if.sv
rtl/tcw_ram.sv
rtl/tcw_ctrl.sv
rtl/tcw_datapath.sv
rtl/text_console_char_writer_core.sv
tb/sv/testbench.sv
